/* src/lpi_pkg.sv */
package lpi_pkg;

   localparam int COORD_W     = 32;
   localparam int DEN_W       = 64;
   localparam int NUMMAG_W    = 66;
   localparam int TOL_W       = 63;
   localparam int DIV_STEPS   = 32;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef coord_type [2:0] vec3_type;

   // classified query, carried from front to back
   typedef struct packed {
      logic                par;
      logic                neg;
      logic [DEN_W-1:0]    den_mag;
      logic [NUMMAG_W-1:0] num_mag;
      vec3_type            org;
      vec3_type            dir;
   } q_entry_type;

endpackage

/* src/lpi_front.sv */
module lpi_front import lpi_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  vec3_type         org,
   input  vec3_type         dir,
   input  vec3_type         pnt,
   input  vec3_type         nrm,
   input  logic [TOL_W-1:0] tolerance,
   input  logic             q_full,
   output logic             push_valid,
   output q_entry_type      push_entry
);

   logic                     s1_valid_ff, s2_valid_ff;
   vec3_type                 s1_org_ff, s1_dir_ff, s2_org_ff, s2_dir_ff;
   logic signed [63:0]       nd_ff [3];
   logic signed [64:0]       pn_ff [3];
   logic signed [63:0]       nd_in [3];
   logic signed [64:0]       pn_in [3];
   logic signed [32:0]       diff_in [3];
   logic signed [65:0]       den_ff, den_in;
   logic signed [66:0]       num_ff, num_in;
   logic signed [65:0]       den_abs;
   logic signed [66:0]       num_abs;
   logic                     adv;

   assign adv       = !(s2_valid_ff && q_full);
   assign req_ready = adv;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         diff_in[i] = 33'(pnt[i]) - 33'(org[i]);
         nd_in[i]   = 64'(nrm[i]) * 64'(dir[i]);
         pn_in[i]   = 65'(diff_in[i]) * 65'(nrm[i]);
      end
      den_in = 66'(nd_ff[0]) + 66'(nd_ff[1]) + 66'(nd_ff[2]);
      num_in = 67'(pn_ff[0]) + 67'(pn_ff[1]) + 67'(pn_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_org_ff <= org;
         s1_dir_ff <= dir;
         nd_ff     <= nd_in;
         pn_ff     <= pn_in;
         s2_org_ff <= s1_org_ff;
         s2_dir_ff <= s1_dir_ff;
         den_ff    <= den_in;
         num_ff    <= num_in;
      end
   end

   // classify: magnitudes, sign of quotient, parallel test
   always_comb begin
      den_abs = den_ff[65] ? -den_ff : den_ff;
      num_abs = num_ff[66] ? -num_ff : num_ff;
      push_entry.den_mag = den_abs[DEN_W-1:0];
      push_entry.num_mag = num_abs[NUMMAG_W-1:0];
      push_entry.par     = den_abs[DEN_W-1:0] <= {1'b0, tolerance};
      push_entry.neg     = den_ff[65] ^ num_ff[66];
      push_entry.org     = s2_org_ff;
      push_entry.dir     = s2_dir_ff;
   end

   assign push_valid = s2_valid_ff && !q_full;

endmodule

/* src/lpi_fifo.sv */
module lpi_fifo import lpi_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  q_entry_type push_entry,
   output logic        full,
   input  logic        pop,
   output logic        not_empty,
   output q_entry_type head
);

   q_entry_type        mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]  count_ff, count_in;

   assign full      = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign not_empty = count_ff != '0;
   assign head      = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_entry;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH)) else $error("queue count overrun");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0) else $error("pop from empty queue");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full || pop) else $error("push into full queue");

endmodule

/* src/lpi_back.sv */
module lpi_back import lpi_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   input  q_entry_type q_head,
   output logic        q_pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output coord_type   rsp_hit_x,
   output coord_type   rsp_hit_y,
   output coord_type   rsp_hit_z,
   output coord_type   rsp_line_param,
   output logic        rsp_intersects,
   output logic        rsp_saturated
);

   localparam int NW = NUMMAG_W + FRAC_BITS;

   typedef struct packed {
      logic             par;
      logic             neg;
      logic             ovf;
      logic [DEN_W-1:0] den;
      logic [DEN_W-1:0] rem;
      logic [31:0]      nlow;
      logic [31:0]      quo;
      vec3_type         org;
      vec3_type         dir;
   } div_stage_type;

   logic               adv;
   logic [NW-1:0]      nshift;
   div_stage_type      div0_in;
   div_stage_type      div_ff [DIV_STEPS+1];
   logic               dvld_ff [DIV_STEPS+1];

   logic               t_vld_ff, t_par_ff, t_clip_ff;
   coord_type          t_ff, t_in;
   logic               t_clip_in;
   vec3_type           t_org_ff, t_dir_ff;

   logic               m_vld_ff, m_par_ff, m_clip_ff;
   coord_type          m_t_ff;
   vec3_type           m_org_ff;
   logic signed [63:0] prod_ff [3];

   logic signed [64:0] sum_in [3];
   coord_type          pt_in [3];
   logic [2:0]         pclip_in;

   logic               rsp_valid_ff;
   coord_type          hx_ff, hy_ff, hz_ff, tp_ff;
   logic               hit_ff, sat_ff;

   assign adv   = !rsp_valid_ff || rsp_ready;
   assign q_pop = adv && q_valid;

   // split numerator: top part seeds the remainder, low 32 bits feed the steps
   always_comb begin
      nshift         = NW'(q_head.num_mag) << FRAC_BITS;
      div0_in.par    = q_head.par;
      div0_in.neg    = q_head.neg;
      div0_in.den    = q_head.den_mag;
      div0_in.rem    = DEN_W'(nshift[NW-1:32]);
      div0_in.ovf    = DEN_W'(nshift[NW-1:32]) >= q_head.den_mag;
      div0_in.nlow   = nshift[31:0];
      div0_in.quo    = '0;
      div0_in.org    = q_head.org;
      div0_in.dir    = q_head.dir;
   end

   always_ff @(posedge clock) begin
      if (reset) dvld_ff[0] <= 1'b0;
      else if (adv) dvld_ff[0] <= q_valid;
   end

   always_ff @(posedge clock) begin
      if (adv) div_ff[0] <= div0_in;
   end

   for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
      logic [DEN_W:0] trial;
      logic           ge;
      div_stage_type  nxt;

      always_comb begin
         trial    = {div_ff[k-1].rem, div_ff[k-1].nlow[31]};
         ge       = trial >= {1'b0, div_ff[k-1].den};
         nxt      = div_ff[k-1];
         nxt.rem  = ge ? DEN_W'(trial - {1'b0, div_ff[k-1].den}) : trial[DEN_W-1:0];
         nxt.nlow = {div_ff[k-1].nlow[30:0], 1'b0};
         nxt.quo  = {div_ff[k-1].quo[30:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) dvld_ff[k] <= 1'b0;
         else if (adv) dvld_ff[k] <= dvld_ff[k-1];
      end

      always_ff @(posedge clock) begin
         if (adv) div_ff[k] <= nxt;
      end
   end

   // apply sign and clip the quotient to the coordinate range
   always_comb begin
      t_clip_in = 1'b0;
      if (div_ff[DIV_STEPS].neg) begin
         if (div_ff[DIV_STEPS].ovf || div_ff[DIV_STEPS].quo > 32'h8000_0000) begin
            t_clip_in = 1'b1;
            t_in      = COORD_MIN;
         end else begin
            t_in = -$signed(div_ff[DIV_STEPS].quo);
         end
      end else begin
         if (div_ff[DIV_STEPS].ovf || div_ff[DIV_STEPS].quo[31]) begin
            t_clip_in = 1'b1;
            t_in      = COORD_MAX;
         end else begin
            t_in = $signed(div_ff[DIV_STEPS].quo);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t_vld_ff <= 1'b0;
         m_vld_ff <= 1'b0;
      end else if (adv) begin
         t_vld_ff <= dvld_ff[DIV_STEPS];
         m_vld_ff <= t_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t_ff      <= t_in;
         t_clip_ff <= t_clip_in;
         t_par_ff  <= div_ff[DIV_STEPS].par;
         t_org_ff  <= div_ff[DIV_STEPS].org;
         t_dir_ff  <= div_ff[DIV_STEPS].dir;
         m_t_ff    <= t_ff;
         m_clip_ff <= t_clip_ff;
         m_par_ff  <= t_par_ff;
         m_org_ff  <= t_org_ff;
         for (int i = 0; i < 3; i++) prod_ff[i] <= 64'(t_ff) * 64'(t_dir_ff[i]);
      end
   end

   // point = org + floor(t*dir / 2^FRAC_BITS), clipped
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sum_in[i]   = 65'(m_org_ff[i]) + 65'(prod_ff[i] >>> FRAC_BITS);
         pclip_in[i] = 1'b0;
         pt_in[i]    = COORD_W'(sum_in[i]);
         if (sum_in[i] > 65'(COORD_MAX)) begin
            pt_in[i]    = COORD_MAX;
            pclip_in[i] = 1'b1;
         end else if (sum_in[i] < 65'(COORD_MIN)) begin
            pt_in[i]    = COORD_MIN;
            pclip_in[i] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (adv) rsp_valid_ff <= m_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (m_par_ff) begin
            hx_ff  <= '0;
            hy_ff  <= '0;
            hz_ff  <= '0;
            tp_ff  <= '0;
            hit_ff <= 1'b0;
            sat_ff <= 1'b0;
         end else begin
            hx_ff  <= pt_in[0];
            hy_ff  <= pt_in[1];
            hz_ff  <= pt_in[2];
            tp_ff  <= m_t_ff;
            hit_ff <= 1'b1;
            sat_ff <= m_clip_ff || (pclip_in != '0);
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit_x      = hx_ff;
   assign rsp_hit_y      = hy_ff;
   assign rsp_hit_z      = hz_ff;
   assign rsp_line_param = tp_ff;
   assign rsp_intersects = hit_ff;
   assign rsp_saturated  = sat_ff;

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !hit_ff |-> hx_ff == '0 && hy_ff == '0 && hz_ff == '0
                                  && tp_ff == '0 && !sat_ff)
      else $error("miss result not cleared");
   a_pop_moves: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> dvld_ff[0]) else $error("popped entry not captured");
   a_hold_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> $stable(m_vld_ff) && $stable(t_ff))
      else $error("pipeline moved while output stalled");

endmodule

/* src/line_plane_intersection.sv */
// Channel | Direction | Ports         | Content
// req     | in        | req_*         | line origin/direction, plane point/normal
// rsp     | out       | rsp_*         | hit point, line parameter, hit and clip flags
// csr     | in        | csr_*         | parallel tolerance, always ready
//
// One query per cycle sustained while rsp is not stalled; from transfer in to
// rsp_valid a query passes 2 front stages, queue, 33 divider stages, 3 back stages.
// The divider is a restoring pipeline, one quotient bit per stage.
// Synchronous reset empties all stages and the queue, tolerance = 0.001.
// A stalled rsp holds the back; the queue lets the front keep taking items
// until its slots fill.
module line_plane_intersection import lpi_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  coord_type        req_line_origin_x,
   input  coord_type        req_line_origin_y,
   input  coord_type        req_line_origin_z,
   input  coord_type        req_line_dir_x,
   input  coord_type        req_line_dir_y,
   input  coord_type        req_line_dir_z,
   input  coord_type        req_plane_point_x,
   input  coord_type        req_plane_point_y,
   input  coord_type        req_plane_point_z,
   input  coord_type        req_plane_normal_x,
   input  coord_type        req_plane_normal_y,
   input  coord_type        req_plane_normal_z,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output coord_type        rsp_hit_x,
   output coord_type        rsp_hit_y,
   output coord_type        rsp_hit_z,
   output coord_type        rsp_line_param,
   output logic             rsp_intersects,
   output logic             rsp_saturated,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [TOL_W-1:0] csr_parallel_tolerance
);

   localparam logic [TOL_W-1:0] TOL_RESET =
      TOL_W'((64'd1 << (2 * FRAC_BITS)) / 64'd1000);

   logic [TOL_W-1:0] tol_ff;
   logic             push_valid, q_full, q_pop, q_valid;
   q_entry_type      push_entry, q_head;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) tol_ff <= TOL_RESET;
      else if (csr_valid) tol_ff <= csr_parallel_tolerance;
   end

   lpi_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .org        ({req_line_origin_z, req_line_origin_y, req_line_origin_x}),
      .dir        ({req_line_dir_z, req_line_dir_y, req_line_dir_x}),
      .pnt        ({req_plane_point_z, req_plane_point_y, req_plane_point_x}),
      .nrm        ({req_plane_normal_z, req_plane_normal_y, req_plane_normal_x}),
      .tolerance  (tol_ff),
      .q_full     (q_full),
      .push_valid (push_valid),
      .push_entry (push_entry)
   );

   lpi_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push_valid),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .not_empty  (q_valid),
      .head       (q_head)
   );

   lpi_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_head         (q_head),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hit_x      (rsp_hit_x),
      .rsp_hit_y      (rsp_hit_y),
      .rsp_hit_z      (rsp_hit_z),
      .rsp_line_param (rsp_line_param),
      .rsp_intersects (rsp_intersects),
      .rsp_saturated  (rsp_saturated)
   );

endmodule
